@@ rtl/mds_pkg.sv @@
// Package for the downslope mask stencil: payload types, register indexes, constants.
package mds_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int ELEV_W        = 32;
    localparam int MASK_W        = 8;
    localparam int FW_W          = 13;
    localparam int FH_W          = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    // compare width for sizes: holds MAX_WIDTH up to 65536 and row count + 1
    localparam int CMP_W         = 17;

    localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 13'd4096;
    localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 16'd4096;
    localparam logic signed [ELEV_W-1:0] NODATA_RST = -32'sd9999;

    // neighbour direction bits
    localparam logic [MASK_W-1:0] DIR_E  = 8'd1;
    localparam logic [MASK_W-1:0] DIR_SE = 8'd2;
    localparam logic [MASK_W-1:0] DIR_S  = 8'd4;
    localparam logic [MASK_W-1:0] DIR_SW = 8'd8;
    localparam logic [MASK_W-1:0] DIR_W  = 8'd16;
    localparam logic [MASK_W-1:0] DIR_NW = 8'd32;
    localparam logic [MASK_W-1:0] DIR_N  = 8'd64;
    localparam logic [MASK_W-1:0] DIR_NE = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_NODATA       = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [ELEV_W-1:0] elevation;
        logic [MASK_W-1:0]        prior_mask;
    } t_in_item;

    typedef struct packed {
        logic [MASK_W-1:0] flow_mask;
        logic              end_of_row;
        logic              end_of_frame;
    } t_out_item;

    // position flags of one pixel, taken at acceptance
    typedef struct packed {
        logic emit;
        logic last_col;
        logic last_row;
    } t_pos_flags;

endpackage

@@ rtl/mds_ctrl.sv @@
// Configuration registers and raster position counters.
module mds_ctrl
    import mds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_acc,
    output logic [CW-1:0]               o_col,
    output t_pos_flags                  o_flags,
    output logic signed [ELEV_W-1:0]    o_nodata
);

    logic [FW_W-1:0]          r_fw;
    logic [FH_W-1:0]          r_fh;
    logic signed [ELEV_W-1:0] r_nodata;
    logic [CW-1:0]            r_col, n_col;
    logic [FH_W-1:0]          r_row, n_row;
    logic [CMP_W-1:0]         w_eff, h_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw     <= FRAME_WIDTH_RST;
            r_fh     <= FRAME_HEIGHT_RST;
            r_nodata <= NODATA_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_FRAME_WIDTH:  r_fw     <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_fh     <= i_cfg_data[FH_W-1:0];
                CFG_NODATA:       r_nodata <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp sizes to the supported range
    always_comb begin
        if (CMP_W'(r_fw) < CMP_W'(3))
            w_eff = CMP_W'(3);
        else if (CMP_W'(r_fw) > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = CMP_W'(r_fw);
        h_eff = (r_fh < FH_W'(3)) ? CMP_W'(3) : CMP_W'(r_fh);
    end

    always_comb begin
        o_flags.emit     = (r_row >= FH_W'(2)) && (r_col >= CW'(2));
        o_flags.last_col = (CMP_W'(r_col) + CMP_W'(1)) >= w_eff;
        o_flags.last_row = (CMP_W'(r_row) + CMP_W'(1)) >= h_eff;
        n_col = r_col;
        n_row = r_row;
        if (o_flags.last_col) begin
            n_col = '0;
            n_row = o_flags.last_row ? '0 : r_row + FH_W'(1);
        end else begin
            n_col = r_col + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col    = r_col;
    assign o_nodata = r_nodata;

endmodule

@@ rtl/mds_lbuf.sv @@
// Line buffers: two elevation rows and one prior-mask row, read-first RAMs.
module mds_lbuf
    import mds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF,
    parameter int CW        = $clog2(MAX_WIDTH)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_acc,
    input  logic [CW-1:0]               i_col,
    input  t_in_item                    i_item,
    output logic signed [ELEV_W-1:0]    o_mid,
    output logic signed [ELEV_W-1:0]    o_top,
    output logic [MASK_W-1:0]           o_prior
);

    logic signed [ELEV_W-1:0] mid_mem   [MAX_WIDTH];
    logic signed [ELEV_W-1:0] top_mem   [MAX_WIDTH];
    logic [MASK_W-1:0]        prior_mem [MAX_WIDTH];

    logic signed [ELEV_W-1:0] r_mid, r_top;
    logic [MASK_W-1:0]        r_prior;
    logic                     r_wb_pend;
    logic [CW-1:0]            r_wb_addr;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_mid          <= mid_mem[i_col];
            r_top          <= top_mem[i_col];
            r_prior        <= prior_mem[i_col];
            mid_mem[i_col] <= i_item.elevation;
            prior_mem[i_col] <= i_item.prior_mask;
        end
    end

    // the row above moves up in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (r_wb_pend)
            top_mem[r_wb_addr] <= r_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_wb_pend <= 1'b0;
        else
            r_wb_pend <= i_acc;
        r_wb_addr <= i_col;
    end

    assign o_mid   = r_mid;
    assign o_top   = r_top;
    assign o_prior = r_prior;

endmodule

@@ rtl/mds_dmask.sv @@
// 3x3 elevation window, prior delay and the downslope mask compare.
module mds_dmask
    import mds_pkg::*;
(
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic signed [ELEV_W-1:0]    i_top,
    input  logic signed [ELEV_W-1:0]    i_mid,
    input  logic signed [ELEV_W-1:0]    i_bot,
    input  logic [MASK_W-1:0]           i_prior,
    input  logic signed [ELEV_W-1:0]    i_nodata,
    output logic [MASK_W-1:0]           o_mask
);

    // r_c1/r_c2: window columns 0 and 1, rows top/mid/bottom
    logic signed [ELEV_W-1:0] r_c1 [3];
    logic signed [ELEV_W-1:0] r_c2 [3];
    logic [MASK_W-1:0]        r_pd0, r_pd1;
    logic signed [ELEV_W-1:0] centre;
    logic [MASK_W-1:0]        mask;

    function automatic logic [MASK_W-1:0] dir_bit(
        input logic signed [ELEV_W-1:0] c,
        input logic signed [ELEV_W-1:0] nb,
        input logic signed [ELEV_W-1:0] nd,
        input logic [MASK_W-1:0]        bitv
    );
        return ((nb != nd) && (c > nb)) ? bitv : '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < 3; r++) begin
                r_c1[r] <= '0;
                r_c2[r] <= '0;
            end
            r_pd0 <= '0;
            r_pd1 <= '0;
        end else if (i_adv) begin
            for (int r = 0; r < 3; r++)
                r_c1[r] <= r_c2[r];
            r_c2[0] <= i_top;
            r_c2[1] <= i_mid;
            r_c2[2] <= i_bot;
            r_pd0   <= i_prior;
            r_pd1   <= r_pd0;
        end
    end

    // shifted window: column 0 = r_c1, column 1 = r_c2, column 2 = incoming
    always_comb begin
        centre = r_c2[1];
        mask = dir_bit(centre, i_mid,   i_nodata, DIR_E)
             | dir_bit(centre, i_bot,   i_nodata, DIR_SE)
             | dir_bit(centre, r_c2[2], i_nodata, DIR_S)
             | dir_bit(centre, r_c1[2], i_nodata, DIR_SW)
             | dir_bit(centre, r_c1[1], i_nodata, DIR_W)
             | dir_bit(centre, r_c1[0], i_nodata, DIR_NW)
             | dir_bit(centre, r_c2[0], i_nodata, DIR_N)
             | dir_bit(centre, i_top,   i_nodata, DIR_NE);
        // cell prior is the delay output after this step
        if (r_pd0 == '0)
            o_mask = '0;
        else if (mask != '0)
            o_mask = mask;
        else
            o_mask = r_pd0;
    end

endmodule

@@ rtl/mfd_downslope_mask_stencil.sv @@
// Downslope neighbour mask stencil: top level with handshake and result register.
// A result passes through stage 1 and the result register after its completing pixel's transaction.
// Throughput: one pixel per cycle while the result register is not stalled.
// A stalled result register holds an interior pixel in the line-buffer stage; input stalls only then and in reset.
// Reset (synchronous, active low) clears counters, window, prior delay and valids;
// line buffers are not cleared and hold undefined data until written.
module mfd_downslope_mask_stencil
    import mds_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_item,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_item
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                     acc;
    logic                     adv;
    logic                     out_free;
    logic [CW-1:0]            col;
    t_pos_flags               flags;
    logic signed [ELEV_W-1:0] nodata;
    logic signed [ELEV_W-1:0] lb_mid, lb_top;
    logic [MASK_W-1:0]        lb_prior;
    logic [MASK_W-1:0]        cell_mask;

    // stage 1: line-buffer read data plus the pixel itself
    logic                     r_v1;
    t_pos_flags               r_f1;
    logic signed [ELEV_W-1:0] r_elev1;

    // result register
    logic                     r_ov;
    t_out_item                r_out;

    // stage 1 moves on when its result (if any) has room
    assign out_free   = !r_ov || !i_out_stall;
    assign adv        = r_v1 && (!r_f1.emit || out_free);
    assign o_in_stall = !i_rst_n || (r_v1 && !adv);
    assign acc        = i_in_valid && !o_in_stall;

    mds_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_acc      (acc),
        .o_col      (col),
        .o_flags    (flags),
        .o_nodata   (nodata)
    );

    mds_lbuf #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW)
    ) u_lbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (acc),
        .i_col   (col),
        .i_item  (i_in_item),
        .o_mid   (lb_mid),
        .o_top   (lb_top),
        .o_prior (lb_prior)
    );

    mds_dmask u_dmask (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_top    (lb_top),
        .i_mid    (lb_mid),
        .i_bot    (r_elev1),
        .i_prior  (lb_prior),
        .i_nodata (nodata),
        .o_mask   (cell_mask)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (acc) begin
            r_v1 <= 1'b1;
        end else if (adv) begin
            r_v1 <= 1'b0;
        end
        if (acc) begin
            r_f1    <= flags;
            r_elev1 <= i_in_item.elevation;
        end
    end

    // halo pixels only feed the window; interior cells load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (adv && r_f1.emit) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
        if (adv && r_f1.emit) begin
            r_out.flow_mask    <= cell_mask;
            r_out.end_of_row   <= r_f1.last_col;
            r_out.end_of_frame <= r_f1.last_col && r_f1.last_row;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    // input is held back only while stage 1 is occupied
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_v1)
        else $error("input stalled with empty line-buffer stage");

    // an accepted pixel always occupies stage 1 next cycle
    a_acc_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_v1)
        else $error("accepted transaction lost before stage 1");

    // frame end only ever marks a row end
    a_eof_is_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_item.end_of_frame || o_out_item.end_of_row))
        else $error("end_of_frame without end_of_row");

    // a held result must not be overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_out_stall) |-> !(adv && r_f1.emit))
        else $error("result register overwritten while stalled");

endmodule

@@ dv/tb.sv @@
// Downslope mask stencil testbench: directed cells, size limits, resize, backpressure, random rasters.
`timescale 1ns / 100ps

module tb
    import mds_pkg::*;
();

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int RESET_CYCLES  = 12;
    // result passes stage 1 and the result register after its completing pixel; allow margin
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int GAP_CAP       = 40;    // longest sender gap per pixel
    localparam int STALL_LIMIT   = 3000;  // cycles without any transaction
    localparam int MAX_REPORTS   = 10;

    // no register sits at this index; writes there must do nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 32'sh8000_0000;

    // ------------------------------------------------------------------
    // Clock, reset and block inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  in_valid   = 1'b0;
    t_in_item              in_item    = '0;
    logic                  out_stall  = 1'b0;

    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_item;

    always #5 i_clk = ~i_clk;

    mfd_downslope_mask_stencil dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // ------------------------------------------------------------------
    // Traffic shaping
    // ------------------------------------------------------------------
    int send_idle_pct = 0;   // chance per cycle that the sender idles
    int stall_pct     = 0;   // chance per cycle that the receiver stalls
    bit hold_req      = 1'b0;  // toggled by a test to start a long hold
    bit hold_ack      = 1'b0;
    int hold_left     = 0;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the block's registers and buffers.
    // Two-state storage reads as zero before first write; such reads never
    // reach a result because every frame starts from row 0, column 0.
    // ------------------------------------------------------------------
    logic [FW_W-1:0]            cfg_width  = FRAME_WIDTH_RST;
    logic [FH_W-1:0]            cfg_height = FRAME_HEIGHT_RST;
    logic signed [ELEV_W-1:0]   nodata_reg = NODATA_RST;

    bit signed [ELEV_W-1:0] elev_line [2*MAX_W];  // [0..) row-1, [MAX_W..) row-2
    bit [MASK_W-1:0]        prior_line [MAX_W];
    bit signed [ELEV_W-1:0] win [9];              // 3x3 window, row*3+col
    bit [MASK_W-1:0]        prior_pipe [2];
    int unsigned            col_cnt = 0;
    int unsigned            row_cnt = 0;

    t_out_item expected_masks [$];
    int        mismatches = 0;

    // content used by the random pixel source
    logic signed [ELEV_W-1:0] elev_base = '0;

    // ------------------------------------------------------------------
    // Predictor: advance one accepted pixel, queue the cell it completes
    // ------------------------------------------------------------------
    task automatic compute_downslope(input t_in_item px);
        int unsigned              w;
        int unsigned              h;
        int unsigned              col;
        int                       r;
        int                       i;
        int                       pos;
        logic signed [ELEV_W-1:0] mid;
        logic signed [ELEV_W-1:0] top;
        logic signed [ELEV_W-1:0] centre;
        logic signed [ELEV_W-1:0] nb;
        logic [MASK_W-1:0]        dir;
        logic [MASK_W-1:0]        old_prior;
        logic [MASK_W-1:0]        cell_prior;
        logic [MASK_W-1:0]        mask;
        bit                       last_col;
        bit                       last_row;
        t_out_item                res;

        // effective sizes: width clamped to 3..MAX_W, height at least 3
        w = 32'(cfg_width);
        if (w < 3) w = 3;
        if (w > MAX_W) w = MAX_W;
        h = 32'(cfg_height);
        if (h < 3) h = 3;
        col = col_cnt % MAX_W;

        mid = elev_line[col];
        top = elev_line[MAX_W + col];
        elev_line[MAX_W + col] = mid;
        elev_line[col]         = px.elevation;

        for (r = 0; r < 3; r++) begin
            win[r*3 + 0] = win[r*3 + 1];
            win[r*3 + 1] = win[r*3 + 2];
        end
        win[2] = top;
        win[5] = mid;
        win[8] = px.elevation;

        old_prior       = prior_line[col];
        prior_line[col] = px.prior_mask;
        prior_pipe[1]   = prior_pipe[0];
        prior_pipe[0]   = old_prior;

        last_col = (col_cnt + 1 >= w);
        last_row = (row_cnt + 1 >= h);

        if (row_cnt >= 2 && col_cnt >= 2) begin
            centre     = win[4];
            cell_prior = prior_pipe[1];
            mask       = '0;
            for (i = 0; i < 8; i++) begin
                // window slot and direction bit of each neighbour
                case (i)
                    0: begin pos = 5; dir = DIR_E;  end
                    1: begin pos = 8; dir = DIR_SE; end
                    2: begin pos = 7; dir = DIR_S;  end
                    3: begin pos = 6; dir = DIR_SW; end
                    4: begin pos = 3; dir = DIR_W;  end
                    5: begin pos = 0; dir = DIR_NW; end
                    6: begin pos = 1; dir = DIR_N;  end
                    default: begin pos = 2; dir = DIR_NE; end
                endcase
                nb = win[pos];
                if (nb != nodata_reg && centre > nb) mask = mask | dir;
            end
            if (cell_prior == '0) res.flow_mask = '0;
            else if (mask != '0)  res.flow_mask = mask;
            else                  res.flow_mask = cell_prior;
            res.end_of_row   = last_col;
            res.end_of_frame = last_col && last_row;
            expected_masks.push_back(res);
        end

        if (last_col) begin
            col_cnt = 0;
            if (last_row) row_cnt = 0;
            else          row_cnt = (row_cnt + 1) & 32'hFFFF;
        end else begin
            col_cnt = col_cnt + 1;
        end
    endtask

    // ------------------------------------------------------------------
    // Register write: only called while the block is idle
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        case (idx)
            CFG_FRAME_WIDTH:  cfg_width  = data[FW_W-1:0];
            CFG_FRAME_HEIGHT: cfg_height = data[FH_W-1:0];
            CFG_NODATA:       nodata_reg = signed'(data[ELEV_W-1:0]);
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // One pixel transaction. Valid is left high after acceptance so that a
    // back-to-back pixel only changes the payload in the next step.
    // ------------------------------------------------------------------
    task automatic send_pixel(input logic signed [ELEV_W-1:0] elev,
                              input logic [MASK_W-1:0] prior);
        int       gap;
        t_in_item px;
        gap = 0;
        while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
        px.elevation  = elev;
        px.prior_mask = prior;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= px;
        do @(posedge i_clk); while (in_stall);
        compute_downslope(px);
    endtask

    // drop valid, let every queued cell arrive, then let the pipe settle
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_masks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [ELEV_W-1:0] random_elevation();
        case ($urandom_range(9))
            0:       return nodata_reg;
            1:       return $urandom;
            2:       return $urandom_range(1) ? ELEV_MAX : ELEV_MIN;
            default: return elev_base + $urandom_range(6);  // near values give rich masks
        endcase
    endfunction

    function automatic logic [MASK_W-1:0] random_prior();
        if ($urandom_range(7) == 0) return '0;
        return MASK_W'($urandom_range(255));
    endfunction

    task automatic send_frame(input int w, input int h);
        repeat (w * h) send_pixel(random_elevation(), random_prior());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built cells under the reset nodata code: local pit (prior passes
    // through), peak next to nodata and equal neighbours, nodata prior, and
    // a centre above all eight neighbours.
    task automatic test_directed_cells();
        logic signed [ELEV_W-1:0] grid [15];
        logic [MASK_W-1:0]        pri  [15];
        int                       k;
        send_idle_pct = 0;
        stall_pct    <= 0;
        write_reg(CFG_FRAME_WIDTH, 5);
        write_reg(CFG_FRAME_HEIGHT, 3);
        grid = '{32'sd3, NODATA_RST, 32'sd3, 32'sd3, 32'sd3,
                 32'sd0, ELEV_MIN, ELEV_MAX, 32'sd7, 32'sd2,
                 32'sd1, ELEV_MAX, NODATA_RST, ELEV_MAX, 32'sd6};
        pri  = '{8'h11, 8'h11, 8'h11, 8'h11, 8'h11,
                 8'h22, 8'hA5, 8'hFF, 8'h00, 8'h33,
                 8'h44, 8'h44, 8'h44, 8'h44, 8'h44};
        for (k = 0; k < 15; k++) send_pixel(grid[k], pri[k]);
        wait_drain();

        write_reg(CFG_FRAME_WIDTH, 3);
        for (k = 0; k < 9; k++)
            send_pixel((k == 4) ? 32'sd0 : -32'sd1, (k == 4) ? 8'h80 : 8'h01);
        wait_drain();
    endtask

    // Sizes below their ranges, nodata at both extremes, upper data bits
    // ignored, the spare index ignored.
    task automatic test_size_limits();
        send_idle_pct = 20;
        stall_pct    <= 20;
        elev_base     = $urandom;
        write_reg(CFG_FRAME_WIDTH, 0);
        write_reg(CFG_FRAME_HEIGHT, 0);
        write_reg(CFG_NODATA, ELEV_MIN);
        send_frame(3, 3);
        wait_drain();

        write_reg(CFG_FRAME_WIDTH, 2);
        write_reg(CFG_FRAME_HEIGHT, 1);
        write_reg(CFG_NODATA, ELEV_MAX);
        send_frame(3, 3);
        wait_drain();

        write_reg(CFG_FRAME_WIDTH, 1);
        write_reg(CFG_FRAME_HEIGHT, 2);
        write_reg(CFG_UNUSED, $urandom);
        send_frame(3, 3);
        wait_drain();

        // data bits above each register's width are dropped
        send_idle_pct = 0;
        stall_pct    <= 0;
        write_reg(CFG_FRAME_WIDTH, 32'hFFFF_E005);
        write_reg(CFG_FRAME_HEIGHT, 32'hFFFF_0003);
        send_frame(5, 3);
        wait_drain();
    endtask

    // Tallest frame, then both sizes shrunk part-way through a row: the
    // counters sit past the new limits and must wrap on the next pixel.
    task automatic test_resize_mid_frame();
        send_idle_pct = 20;
        stall_pct    <= 20;
        elev_base     = $urandom;
        write_reg(CFG_FRAME_WIDTH, 8);
        write_reg(CFG_FRAME_HEIGHT, 16'hFFFF);
        write_reg(CFG_NODATA, elev_base + 3);
        repeat (3 * 8 + 5) send_pixel(random_elevation(), random_prior());
        wait_drain();

        write_reg(CFG_FRAME_WIDTH, 4);
        write_reg(CFG_FRAME_HEIGHT, 3);
        send_pixel(random_elevation(), random_prior());
        send_frame(4, 3);
        wait_drain();
    endtask

    // Receiver holds off for a long stretch while pixels keep coming, so
    // the block fills and stalls its input; then the sender pauses until
    // every cell has arrived, and a second frame runs with random gaps and stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        stall_pct    <= 0;
        elev_base     = $urandom;
        write_reg(CFG_FRAME_WIDTH, 10);
        write_reg(CFG_FRAME_HEIGHT, 8);
        hold_req <= ~hold_req;
        send_frame(10, 8);
        wait_drain();
        send_idle_pct = 20;
        stall_pct    <= 20;
        send_frame(10, 8);
        wait_drain();
    endtask

    // Random rasters, mostly small, a few wide and short; a size group may
    // run several frames back to back.
    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
        int sent;
        int w;
        int h;
        int reps;
        sent          = 0;
        send_idle_pct = send_pct;
        stall_pct    <= recv_pct;
        case ($urandom_range(3))
            0:       write_reg(CFG_NODATA, ELEV_MIN);
            1:       write_reg(CFG_NODATA, ELEV_MAX);
            default: write_reg(CFG_NODATA, $urandom);
        endcase
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) begin
                w = $urandom_range(70, 3);
                h = 3;
            end else begin
                w = $urandom_range(12, 3);
                h = $urandom_range(10, 3);
            end
            write_reg(CFG_FRAME_WIDTH, w);
            write_reg(CFG_FRAME_HEIGHT, h);
            // nodata often lands among the frame's own values
            if ($urandom_range(1)) begin
                elev_base = nodata_reg - $urandom_range(3);
            end else begin
                elev_base = $urandom;
            end
            reps = $urandom_range(3, 1);
            repeat (reps) begin
                send_frame(w, h);
                sent += w * h;
            end
            wait_drain();
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, or a long hold on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result check: each result transaction against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_masks.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected result: flow_mask %02h eor %b eof %b",
                             out_item.flow_mask, out_item.end_of_row, out_item.end_of_frame);
                mismatches++;
            end else begin
                want = expected_masks.pop_front();
                if (want.flow_mask !== out_item.flow_mask ||
                    want.end_of_row !== out_item.end_of_row ||
                    want.end_of_frame !== out_item.end_of_frame) begin
                    if (mismatches < MAX_REPORTS)
                        $display("mismatch: mask exp %02h got %02h, eor %b/%b, eof %b/%b",
                                 want.flow_mask, out_item.flow_mask,
                                 want.end_of_row, out_item.end_of_row,
                                 want.end_of_frame, out_item.end_of_frame);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transaction on either channel
    // ------------------------------------------------------------------
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_cells();
        test_size_limits();
        test_resize_mid_frame();
        test_backpressure();
        test_random_traffic(0, 0, 120);
        test_random_traffic(62, 0, 120);
        test_random_traffic(0, 62, 120);
        test_random_traffic(20, 20, 120);
        wait_drain();

        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/mds_pkg.sv
rtl/mds_ctrl.sv
rtl/mds_lbuf.sv
rtl/mds_dmask.sv
rtl/mfd_downslope_mask_stencil.sv
dv/tb.sv
